FILE: rtl/core/tlpw_pkg.sv
// tlpw_pkg: shared types and constants for the three-level page walk unit
// no dependencies; used by tlpw_ram and the top level
`default_nettype none

package tlpw_pkg;

	localparam int INDEX_BITS  = 7;
	localparam int OFFSET_BITS = 11;
	localparam int CFG_IDX_W   = 1;

	// request kinds
	localparam logic [1:0] KIND_VREAD  = 2'd0;
	localparam logic [1:0] KIND_VWRITE = 2'd1;
	localparam logic [1:0] KIND_PWRITE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_FLAGS = 1'd1;

	localparam logic [7:0] FLAGS_RESET = 8'h03;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       fault;
		logic       fault_seen;
	} rsp_t;

	// memory port control
	typedef struct packed {
		logic       en;
		logic [3:0] be;
	} mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlpw_wrap.sv
// tlpw_wrap: reduces a 33-bit physical byte address modulo the memory size
// depends on nothing but its parameter; used by the top level
`default_nettype none

module tlpw_wrap #(
	parameter int MEM_WORDS = 16384
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [32:0]                  byte_addr,
	output logic                              done,
	output logic [$clog2(MEM_WORDS)-1:0]      word_idx,
	output logic [1:0]                        lane
);

	localparam int AW      = $clog2(MEM_WORDS);
	localparam int MW1     = AW + 1;
	localparam int RW      = 32 - AW;
	localparam int PW      = 31 + RW;
	localparam bit IS_POW2 = (MEM_WORDS == (1 << AW));
	// floor(2^31 / MEM_WORDS); the quotient estimate is exact or one low
	localparam logic [RW-1:0]  RECIP = RW'((64'd1 << 31) / 64'(MEM_WORDS));
	localparam logic [MW1-1:0] MODW  = MW1'(MEM_WORDS);
	localparam logic [1:0]     STEPS = IS_POW2 ? 2'd0 : 2'd3;

	// remaining reduction steps
	localparam logic [1:0] STEP_MUL = 2'd3;
	localparam logic [1:0] STEP_SUB = 2'd2;
	localparam logic [1:0] STEP_FIX = 2'd1;

	logic [30:0]    x_q;
	logic [1:0]     lane_q;
	logic [PW-1:0]  prod_q;
	logic [MW1-1:0] rem_q;
	logic [1:0]     cnt_q;
	logic [RW-1:0]  quot;
	logic [31:0]    diff;

	// word index is the byte address over four, reduced modulo MEM_WORDS; lane the low two bits
	assign quot = prod_q[PW-1:31];
	assign diff = {1'b0, x_q} - 32'(quot) * 32'(MEM_WORDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// reciprocal multiply, subtract, then one correcting subtract
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= byte_addr[32:2];
			lane_q <= byte_addr[1:0];
		end
		if (cnt_q == STEP_MUL) begin
			prod_q <= PW'(x_q) * PW'(RECIP);
		end
		if (cnt_q == STEP_SUB) begin
			rem_q <= MW1'(diff);
		end else if (cnt_q == STEP_FIX && rem_q >= MODW) begin
			rem_q <= rem_q - MODW;
		end
	end

	assign done     = (cnt_q == '0);
	assign word_idx = IS_POW2 ? x_q[AW-1:0] : rem_q[AW-1:0];
	assign lane     = lane_q;

endmodule

`default_nettype wire

FILE: rtl/core/tlpw_ram.sv
// tlpw_ram: single-port word memory with byte enables and registered read
// depends on tlpw_pkg for the port control struct
`default_nettype none

module tlpw_ram #(
	parameter int WORDS = 16384
) (
	input  wire logic                       clk,
	input  wire tlpw_pkg::mem_ctl_t         ctl,
	input  wire logic [$clog2(WORDS)-1:0]   addr,
	input  wire logic [31:0]                wdata,
	output logic [31:0]                     rdata
);

	logic [31:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 4; i++) begin
				if (ctl.be[i]) begin
					mem[addr][8*i +: 8] <= wdata[8*i +: 8];
				end
			end
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/three_level_page_walk_mmu_unit.sv
// three_level_page_walk_mmu_unit: top level of the page walk unit
// depends on tlpw_pkg, tlpw_wrap and tlpw_ram
`default_nettype none

// Translates 32-bit virtual addresses through three table levels (7+7+7 index
// bits, 11-bit page offset) held in an internal word memory of MEM_WORDS words,
// and performs virtual byte reads, virtual byte writes and physical word writes
// (the latter load the tables and data). Every table entry on the path must
// carry all bits of required_flags, else the item faults, has no effect, and
// the sticky fault bit sets until reset. One item is in flight at a time; the
// result sits in an output register so the next item may be taken while it
// waits. All work goes through one memory port and one address adder feeding
// a modulo unit. For MEM_WORDS not a power of two each address formed also
// passes the unit's reciprocal multiply, subtract and correcting subtract
// (four addresses per translated access, one per physical write).
// Memory contents are undefined until written; no clearing pass runs.
// The config port is always ready and must only be written while idle.

module three_level_page_walk_mmu_unit #(
	parameter int MEM_WORDS = 16384
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request items
	input  wire logic                                req_valid,
	output logic                                     req_ready,
	input  wire tlpw_pkg::req_t                      req,
	// result items
	output logic                                     rsp_valid,
	input  wire logic                                rsp_ready,
	output tlpw_pkg::rsp_t                           rsp,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tlpw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [31:0]                         cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_RED   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [1:0] LAST_LEVEL = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  level_q;
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;
	logic [23:0] table_q;     // bits 31:8 of current table or page base
	logic [7:0]  byte_q;
	logic        fault_q;
	logic        sticky_q;
	logic [23:0] root_q;
	logic [7:0]  flags_q;
	logic        rsp_valid_q;
	tlpw_pkg::rsp_t rsp_q;

	// shared address path
	localparam int INDEX_W = tlpw_pkg::INDEX_BITS;
	logic [INDEX_W-1:0] idx;
	logic [32:0] sum;
	logic        wrap_start;
	logic        wrap_done;
	logic [AW-1:0] word_idx;
	logic [1:0]  lane;

	// memory port
	tlpw_pkg::mem_ctl_t mem_ctl;
	logic [31:0] mem_wdata;
	logic [31:0] mem_rdata;

	logic req_take;
	logic entry_ok;
	logic out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// table index for the current level
	always_comb begin
		unique case (level_q)
			2'd0:    idx = addr_q[31:25];
			2'd1:    idx = addr_q[24:18];
			default: idx = addr_q[17:11];
		endcase
	end

	// one adder forms every physical byte address before wrap
	always_comb begin
		if (kind_q == tlpw_pkg::KIND_PWRITE) begin
			sum = {1'b0, addr_q};
		end else if (level_q == LAST_LEVEL) begin
			sum = {1'b0, table_q, 8'h00}
				+ 33'({addr_q[tlpw_pkg::OFFSET_BITS-1:0]});
		end else begin
			sum = {1'b0, table_q, 8'h00} + 33'({idx, 2'b00});
		end
	end

	assign wrap_start = (state_q == ST_ADDR);

	tlpw_wrap #(
		.MEM_WORDS(MEM_WORDS)
	) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (wrap_start),
		.byte_addr (sum),
		.done      (wrap_done),
		.word_idx  (word_idx),
		.lane      (lane)
	);

	// memory op issued once the wrapped address is ready
	always_comb begin
		mem_ctl   = '0;
		mem_wdata = data_q;
		if (state_q == ST_RED && wrap_done) begin
			mem_ctl.en = 1'b1;
			if (kind_q == tlpw_pkg::KIND_PWRITE) begin
				mem_ctl.be = 4'b1111;
			end else if (level_q == LAST_LEVEL && kind_q == tlpw_pkg::KIND_VWRITE) begin
				mem_ctl.be = 4'b0001 << lane;
				mem_wdata  = {4{data_q[7:0]}};
			end
		end
	end

	tlpw_ram #(
		.WORDS(MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (word_idx),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign entry_ok = ((mem_rdata[7:0] & flags_q) == flags_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			flags_q <= tlpw_pkg::FLAGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlpw_pkg::CFG_ROOT_BASE: root_q  <= cfg_data[31:8];
				tlpw_pkg::CFG_REQ_FLAGS: flags_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and sticky fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			sticky_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result replaces one taken at the same edge
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						level_q <= '0;
						if (req.kind == tlpw_pkg::KIND_VREAD
							|| req.kind == tlpw_pkg::KIND_VWRITE
							|| req.kind == tlpw_pkg::KIND_PWRITE) begin
							state_q <= ST_ADDR;
						end else begin
							state_q <= ST_OUT;  // unused kind, no effect
						end
					end
				end
				ST_ADDR: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (wrap_done) begin
						if (kind_q == tlpw_pkg::KIND_PWRITE) begin
							state_q <= ST_OUT;
						end else if (level_q != LAST_LEVEL) begin
							state_q <= ST_CHECK;
						end else if (kind_q == tlpw_pkg::KIND_VREAD) begin
							state_q <= ST_DATA;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CHECK: begin
					if (entry_ok) begin
						level_q <= level_q + 1'b1;
						state_q <= ST_ADDR;
					end else begin
						sticky_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_DATA: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_q  <= req.kind;
			addr_q  <= req.address;
			data_q  <= req.write_data;
			table_q <= root_q;
			byte_q  <= '0;
			fault_q <= 1'b0;
		end
		if (state_q == ST_CHECK) begin
			if (entry_ok) begin
				table_q <= mem_rdata[31:8];
			end else begin
				fault_q <= 1'b1;
			end
		end
		if (state_q == ST_DATA) begin
			byte_q <= mem_rdata[{lane, 3'b000} +: 8];
		end
		if (state_q == ST_OUT && out_free) begin
			rsp_q.read_byte  <= byte_q;
			rsp_q.fault      <= fault_q;
			rsp_q.fault_seen <= sticky_q;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/three_level_page_walk_mmu_unit_tb.sv
// three_level_page_walk_mmu_unit_tb: self-checking bench for the three-level page walk unit
// depends on tlpw_pkg and three_level_page_walk_mmu_unit; drives random and directed items
// and checks each result against an in-bench model of the tables, memory and sticky fault
module three_level_page_walk_mmu_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_WORDS = 16384;
	localparam longint unsigned MEM_BYTES = 64'(MEM_WORDS) * 4;
	// the fourth kind code has no operation behind it
	localparam logic [1:0] KIND_NONE = 2'd3;
	// idle cycles with no item moving on any channel before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 65;
	localparam int PHASES = 6;

	typedef struct {
		tlpw_pkg::req_t req;
		tlpw_pkg::rsp_t answer;
	} planned_access_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	tlpw_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	tlpw_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [tlpw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// model of the block: word memory, which words were ever stored, config, sticky fault
	bit [31:0] phys_mem [MEM_WORDS];
	bit phys_written [MEM_WORDS];
	logic [31:0] root_base = '0;
	logic [7:0] req_flags = tlpw_pkg::FLAGS_RESET;
	bit fault_latched;

	// accesses waiting to be sent, each with the result the model gave it
	planned_access_t plan_q[$];
	// results owed by the block for accesses it has taken, oldest first
	tlpw_pkg::rsp_t result_due_q[$];
	int open_items;
	int stim_count;
	int error_count;

	bit send_pause_on;
	bit recv_pause_on;

	three_level_page_walk_mmu_unit #(
		.MEM_WORDS(MEM_WORDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// physical byte address, carry kept, folded onto the memory size
	function automatic int unsigned word_of(input logic [32:0] byte_addr);
		return int'((64'(byte_addr) % MEM_BYTES) >> 2);
	endfunction

	// walks the three levels with the current config; also returns the first word the walk
	// touched that was never stored (-1 if none), which the generator must fill first
	function automatic bit walk_tables(input logic [31:0] va, output int unsigned pa_word,
			output logic [1:0] pa_lane, output int hole);
		logic [31:0] base;
		logic [31:0] entry;
		logic [6:0] idx;
		logic [32:0] byte_addr;
		int unsigned w;
		base = {root_base[31:8], 8'h00};
		hole = -1;
		pa_word = 0;
		pa_lane = 2'd0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			idx = va[31 - 7 * lvl -: 7];
			byte_addr = {1'b0, base} + {24'd0, idx, 2'b00};
			w = word_of(byte_addr);
			if (!phys_written[w] && hole < 0)
				hole = w;
			entry = phys_mem[w];
			// every required flag must be present on each level
			if ((entry[7:0] & req_flags) != req_flags)
				return 1'b0;
			base = {entry[31:8], 8'h00};
		end
		byte_addr = {1'b0, base} + {22'd0, va[10:0]};
		pa_word = word_of(byte_addr);
		pa_lane = 2'(64'(byte_addr) % MEM_BYTES);
		if (!phys_written[pa_word] && hole < 0)
			hole = pa_word;
		return 1'b1;
	endfunction

	// applies one access to the model and returns the result the block owes for it
	function automatic tlpw_pkg::rsp_t predict_access(input tlpw_pkg::req_t r);
		tlpw_pkg::rsp_t res;
		int unsigned w;
		logic [1:0] lane;
		int hole;
		res = '0;
		case (r.kind)
			tlpw_pkg::KIND_VREAD, tlpw_pkg::KIND_VWRITE: begin
				if (!walk_tables(r.address, w, lane, hole)) begin
					// faulting access leaves memory alone and reads as zero
					res.fault = 1'b1;
					fault_latched = 1'b1;
				end else if (r.kind == tlpw_pkg::KIND_VREAD) begin
					res.read_byte = phys_mem[w][8 * lane +: 8];
				end else begin
					phys_mem[w][8 * lane +: 8] = r.write_data[7:0];
				end
			end
			tlpw_pkg::KIND_PWRITE: begin
				// low address bits dropped, whole word stored
				w = word_of({1'b0, r.address});
				phys_mem[w] = r.write_data;
				phys_written[w] = 1'b1;
			end
			default: ;
		endcase
		res.fault_seen = fault_latched;
		return res;
	endfunction

	task automatic queue_item(input logic [1:0] kind, input logic [31:0] addr,
			input logic [31:0] data);
		planned_access_t p;
		p.req.kind = kind;
		p.req.address = addr;
		p.req.write_data = data;
		p.answer = predict_access(p.req);
		plan_q.push_back(p);
		open_items++;
		if (kind != KIND_NONE)
			stim_count++;
	endtask

	// virtual access, preceded by the table and data stores its walk still lacks
	task automatic queue_access(input logic [1:0] kind, input logic [31:0] va,
			input logic [31:0] data);
		int unsigned w;
		logic [1:0] lane;
		int hole;
		bit mapped;
		// each store fixes the first hole; at most three entries and one data word
		repeat (4) begin
			mapped = walk_tables(va, w, lane, hole);
			if (hole >= 0)
				queue_item(tlpw_pkg::KIND_PWRITE,
					(32'(hole) << 2) | 32'($urandom_range(0, 3)),
					($urandom_range(0, 6) != 0) ?
					{24'($urandom), req_flags | (8'($urandom) & 8'($urandom))} :
					32'($urandom));
		end
		queue_item(kind, va, data);
	endtask

	// mostly a few low indexes so walks share tables, now and then any index
	function automatic logic [6:0] pick_index();
		if ($urandom_range(0, 3) != 0)
			return 7'($urandom_range(0, 3));
		return 7'($urandom);
	endfunction

	function automatic int pause_len(input bit on);
		if (!on || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	task automatic write_cfg(input logic [tlpw_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tlpw_pkg::CFG_ROOT_BASE: root_base = value;
			tlpw_pkg::CFG_REQ_FLAGS: req_flags = value[7:0];
			default: ;
		endcase
	endtask

	// every queued item answered, block idle
	task automatic settle();
		while (open_items != 0)
			@(posedge clk);
	endtask

	task automatic flag_error(input string what);
		if (error_count < 200)
			$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// request driver: holds an item until taken, then waits its drawn gap
	planned_access_t plan_head;
	tlpw_pkg::rsp_t req_answer;
	int send_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait = 0;
		end else begin
			if (req_valid && req_ready)
				result_due_q.push_back(req_answer);
			if (!req_valid || req_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					req_valid <= 1'b0;
				end else if (plan_q.size() > 0) begin
					plan_head = plan_q.pop_front();
					req <= plan_head.req;
					req_answer = plan_head.answer;
					req_valid <= 1'b1;
					send_wait = pause_len(send_pause_on);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each taken result, then stalls for a drawn count
	tlpw_pkg::rsp_t due_result;
	int recv_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (result_due_q.size() == 0) begin
					flag_error($sformatf("result with no access outstanding: byte %h fault %b",
						rsp.read_byte, rsp.fault));
				end else begin
					due_result = result_due_q.pop_front();
					open_items--;
					if (rsp.read_byte !== due_result.read_byte)
						flag_error($sformatf("read_byte %h, model %h",
							rsp.read_byte, due_result.read_byte));
					if (rsp.fault !== due_result.fault)
						flag_error($sformatf("fault %b, model %b",
							rsp.fault, due_result.fault));
					if (rsp.fault_seen !== due_result.fault_seen)
						flag_error($sformatf("fault_seen %b, model %b",
							rsp.fault_seen, due_result.fault_seen));
				end
				recv_wait = pause_len(recv_pause_on);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog: too long with nothing taken on any channel
	int quiet_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("three_level_page_walk_mmu_unit_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] va;
		logic [31:0] va_wrap;
		logic [31:0] new_root;
		logic [7:0] new_flags;
		int unsigned roll;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_pause_on = 1'b1;
		recv_pause_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset config: root table at 0, read and write flags required
		// top index 0, second 127, third 0, offset at the very end of the page
		va_wrap = {7'd0, 7'd127, 7'd0, 11'h7FF};
		queue_item(KIND_NONE, '1, '1);
		// unaligned store fills the whole top entry; next level at the top of the space
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_0003, 32'hFFFF_FF03);
		// second-level entry sits past the 32-bit carry and folds back low
		queue_item(tlpw_pkg::KIND_PWRITE, 32'hABCD_00FC, 32'h0001_00FF);
		// page base plus offset carries out of 32 bits
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_06FC, 32'hA5C3_0F81);
		queue_access(tlpw_pkg::KIND_VREAD, va_wrap, '0);
		queue_access(tlpw_pkg::KIND_VWRITE, va_wrap, 32'hFFFF_FF5A);
		queue_access(tlpw_pkg::KIND_VREAD, va_wrap, '0);
		queue_access(tlpw_pkg::KIND_VREAD, {va_wrap[31:2], 2'b00}, '0);
		queue_access(tlpw_pkg::KIND_VWRITE, {va_wrap[31:2], 2'b00}, '0);
		queue_access(tlpw_pkg::KIND_VREAD, '0, '1);
		// top entry 127 lacks the write flag
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_01FC, 32'h0000_2001);
		queue_access(tlpw_pkg::KIND_VREAD, '1, '0);
		queue_access(tlpw_pkg::KIND_VWRITE, '1, '1);
		queue_item(KIND_NONE, '0, '0);
		queue_access(tlpw_pkg::KIND_VREAD, va_wrap, '0);
		// fault on the second level
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_0004, 32'h0000_2003);
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_2000, 32'h0000_3001);
		queue_access(tlpw_pkg::KIND_VREAD, {7'd1, 7'd0, 7'd0, 11'h000}, '0);
		// fault on the last level
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_2004, 32'h0000_3007);
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0000_3014, 32'h0000_4002);
		queue_access(tlpw_pkg::KIND_VWRITE, {7'd1, 7'd1, 7'd5, 11'h123}, '1);
		queue_item(tlpw_pkg::KIND_PWRITE, '1, '1);
		// all-zero entry folded onto word 2
		queue_item(tlpw_pkg::KIND_PWRITE, 32'h0001_0008, '0);
		queue_access(tlpw_pkg::KIND_VREAD, {7'd2, 7'd3, 7'd4, 11'h555}, '0);
		settle();

		// random phases, each with its own config and idling mix
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					// no flags required, root at the top of the space
					new_root = 32'hFFFF_FF00;
					new_flags = 8'h00;
				end
				1: begin
					new_root = {24'($urandom), 8'h00};
					new_flags = 8'hFF;
				end
				2: begin
					new_root = '0;
					new_flags = tlpw_pkg::FLAGS_RESET;
				end
				default: begin
					new_root = $urandom_range(0, 1) ? 32'hFFFF_FF00 : {24'($urandom), 8'h00};
					new_flags = 8'($urandom) & 8'($urandom);
				end
			endcase
			write_cfg(tlpw_pkg::CFG_ROOT_BASE, new_root);
			write_cfg(tlpw_pkg::CFG_REQ_FLAGS, {24'd0, new_flags});
			send_pause_on = (phase != 1) && (phase != 3);
			recv_pause_on = (phase != 2) && (phase != 3);
			stim_count = 0;
			while (stim_count < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 72) begin
					// mapped address, a burst of byte reads and writes in one word
					va = {pick_index(), pick_index(), pick_index(), 11'($urandom)};
					repeat ($urandom_range(1, 4))
						queue_access($urandom_range(0, 1) ?
							tlpw_pkg::KIND_VWRITE : tlpw_pkg::KIND_VREAD,
							{va[31:2], 2'($urandom)}, $urandom);
				end else if (roll < 82) begin
					// stray word store anywhere, may clobber tables
					queue_item(tlpw_pkg::KIND_PWRITE, $urandom, $urandom);
				end else if (roll < 89) begin
					// overwrite a top-level entry with junk
					queue_item(tlpw_pkg::KIND_PWRITE,
						{root_base[31:8], 8'h00} + {23'd0, 7'($urandom), 2'b00}, $urandom);
				end else if (roll < 94) begin
					queue_item(KIND_NONE, $urandom, $urandom);
				end else begin
					queue_access($urandom_range(0, 1) ?
						tlpw_pkg::KIND_VWRITE : tlpw_pkg::KIND_VREAD,
						$urandom, $urandom);
				end
			end
			settle();
		end

		// let any late result show up
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("three_level_page_walk_mmu_unit_tb: clean");
		else
			$display("three_level_page_walk_mmu_unit_tb: errors");
		$finish;
	end

endmodule
